FILE: rtl/dcmp_pkg.sv
// ----------------------------------------------------------------------------
// dcmp_pkg
// Shared constants and types of the dc median predictor.
// ----------------------------------------------------------------------------
package dcmp_pkg;

	localparam int MAX_LINE_BLOCKS = 1024;
	localparam int STORE_DEPTH     = MAX_LINE_BLOCKS + 1;
	localparam int ADDR_W          = $clog2(STORE_DEPTH);
	localparam int FILL_W          = $clog2(STORE_DEPTH + 1);
	localparam int DC_W            = 16;
	localparam int CFG_W           = 11;
	localparam int IDX_W           = 12;
	localparam int IN_TDATA_W      = 48;

	typedef enum logic {
		ACT_PREDICT = 1'b0,
		ACT_PUSH    = 1'b1
	} action_t;

	typedef logic signed [DC_W-1:0] dc_t;

	typedef struct packed {
		logic ok;
		dc_t  dc;
	} entry_t;

	// one accepted item as seen by the line store
	typedef struct packed {
		logic adv;
		logic wr;
		logic col0;
		logic row0;
		dc_t  dc;
		logic avail;
	} req_t;

	// neighbors after masking
	typedef struct packed {
		dc_t  dc_a;
		dc_t  dc_u;
		dc_t  dc_l;
		logic ok_a;
		logic ok_u;
		logic ok_l;
	} nbr_t;

endpackage

FILE: rtl/dcmp_line_store.sv
// ----------------------------------------------------------------------------
// dcmp_line_store
// Line of past dc values in two mirrored memories, write pointer, fill count
// and left-neighbor register; delivers masked neighbors in the cycle after issue.
// ----------------------------------------------------------------------------
module dcmp_line_store (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr,
	input  logic [dcmp_pkg::CFG_W-1:0] cfg_data,
	input  dcmp_pkg::req_t          req,
	output dcmp_pkg::nbr_t          nbr_s1
);
	import dcmp_pkg::*;

	logic [ADDR_W-1:0] len_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [ADDR_W-1:0] len_d;
	logic [ADDR_W-1:0] addr_u;
	logic [FILL_W-1:0] depth;
	logic              left_ok_q;
	dc_t               left_dc_q;

	entry_t mem_a [STORE_DEPTH];
	entry_t mem_b [STORE_DEPTH];
	entry_t rd_a_s1;
	entry_t rd_b_s1;
	logic   ok_a_s1;
	logic   ok_u_s1;
	logic   ok_l_s1;
	dc_t    dc_l_s1;

	always_comb begin
		if (cfg_data == '0) begin
			len_d = ADDR_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_LINE_BLOCKS)) begin
			len_d = ADDR_W'(MAX_LINE_BLOCKS);
		end else begin
			len_d = ADDR_W'(cfg_data);
		end
	end

	// above neighbor and next write position coincide
	assign addr_u = (ptr_q == len_q) ? '0 : ptr_q + 1'b1;
	assign depth  = FILL_W'(len_q) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= ADDR_W'(MAX_LINE_BLOCKS);
			ptr_q     <= '0;
			fill_q    <= '0;
			left_ok_q <= 1'b0;
		end else if (cfg_wr) begin
			len_q     <= len_d;
			ptr_q     <= '0;
			fill_q    <= '0;
			left_ok_q <= 1'b0;
		end else if (req.wr) begin
			ptr_q     <= addr_u;
			left_ok_q <= req.avail;
			if (fill_q != depth) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			left_dc_q <= req.dc;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_a[ptr_q] <= '{ok: req.avail, dc: req.dc};
			mem_b[ptr_q] <= '{ok: req.avail, dc: req.dc};
		end
		if (req.adv) begin
			rd_a_s1 <= mem_a[ptr_q];
			rd_b_s1 <= mem_b[addr_u];
		end
	end

	// entries beyond the fill count were never written since the last clear
	always_ff @(posedge clk) begin
		if (req.adv) begin
			ok_a_s1 <= (FILL_W'(ptr_q) < fill_q) && !req.col0 && !req.row0;
			ok_u_s1 <= (FILL_W'(addr_u) < fill_q) && !req.row0;
			ok_l_s1 <= left_ok_q && !req.col0;
			dc_l_s1 <= left_dc_q;
		end
	end

	always_comb begin
		nbr_s1.dc_a = rd_a_s1.dc;
		nbr_s1.dc_u = rd_b_s1.dc;
		nbr_s1.dc_l = dc_l_s1;
		nbr_s1.ok_a = ok_a_s1 && rd_a_s1.ok;
		nbr_s1.ok_u = ok_u_s1 && rd_b_s1.ok;
		nbr_s1.ok_l = ok_l_s1;
	end

endmodule

FILE: rtl/dcmp_pred.sv
// ----------------------------------------------------------------------------
// dcmp_pred
// Median, rounded mean, single-neighbor or zero selection and the output register.
// ----------------------------------------------------------------------------
module dcmp_pred (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ld,
	input  dcmp_pkg::nbr_t        nbr,
	output logic                  ld_ok,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [dcmp_pkg::DC_W-1:0] m_tdata // [15:0] reference
);
	import dcmp_pkg::*;

	dc_t                 lo;
	dc_t                 hi;
	dc_t                 med;
	dc_t                 op_x;
	dc_t                 op_y;
	logic signed [DC_W:0] sum;
	logic signed [DC_W:0] rnd;
	dc_t                 res;
	logic                out_v_q;
	dc_t                 out_q;

	always_comb begin
		lo = (nbr.dc_a < nbr.dc_u) ? nbr.dc_a : nbr.dc_u;
		hi = (nbr.dc_a < nbr.dc_u) ? nbr.dc_u : nbr.dc_a;
		if (nbr.dc_l <= lo) begin
			med = lo;
		end else if (nbr.dc_l >= hi) begin
			med = hi;
		end else begin
			med = nbr.dc_l;
		end
	end

	// operands of the two-neighbor mean
	always_comb begin
		op_x = nbr.dc_a;
		op_y = nbr.dc_l;
		if (nbr.ok_a && nbr.ok_u) begin
			op_y = nbr.dc_u;
		end else if (nbr.ok_u && nbr.ok_l) begin
			op_x = nbr.dc_u;
		end
	end

	// half away from zero
	assign sum = (DC_W+1)'(op_x) + (DC_W+1)'(op_y);
	assign rnd = (sum + {{DC_W{1'b0}}, ~sum[DC_W]}) >>> 1;

	always_comb begin
		case ({nbr.ok_a, nbr.ok_u, nbr.ok_l})
			3'b111: res = med;
			3'b110,
			3'b101,
			3'b011: res = rnd[DC_W-1:0];
			3'b100: res = nbr.dc_a;
			3'b010: res = nbr.dc_u;
			3'b001: res = nbr.dc_l;
			default: res = '0;
		endcase
	end

	assign ld_ok = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ld_ok) begin
			out_v_q <= ld;
		end
	end

	always_ff @(posedge clk) begin
		if (ld && ld_ok) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule

FILE: rtl/dc_median_predictor.sv
// ----------------------------------------------------------------------------
// dc_median_predictor
// Predicts a block dc from its left, above and above-left neighbors.
// ----------------------------------------------------------------------------
// Input stream: s_tuser selects predict or push. A push writes the dc and its
// availability flag into the line store and gives no output transfer. A
// predict gives one reference on the output stream.
// Config channel: cfg_data sets blocks per row (0 acts as 1, large values
// saturate at 1024) and empties the line store; write only while idle.
// Path: a predict passes the read stage register and then the output register
// before it raises m_tvalid.
// Throughput: one item per cycle while s_tready is high; the neighbor reads come
// from two mirrored single-read memories plus a register for the left
// neighbor, so every cycle can issue one store access.
// Reset: the line store reads as empty, blocks per row is 1024, no clearing
// pass is needed since a fill count marks the written entries.
// Stall: the output register holds its result while m_tready is low; pushes
// still pass and one more predict is taken into the read stage, then
// s_tready drops.
// ----------------------------------------------------------------------------
module dc_median_predictor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dcmp_pkg::CFG_W-1:0]    cfg_data,      // [10:0] line_blocks
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dcmp_pkg::IN_TDATA_W-1:0] s_tdata,     // [11:0] column_index,
	                                                     // [23:12] row_index,
	                                                     // [39:24] dc_value,
	                                                     // [40] dc_available
	input  logic [0:0]                    s_tuser,       // [0] action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dcmp_pkg::DC_W-1:0]     m_tdata        // [15:0] reference
);
	import dcmp_pkg::*;

	logic    s_acc;
	action_t act;
	logic    s1_en;
	logic    s1_v_q;
	logic    ld_ok;
	req_t    req;
	nbr_t    nbr_s1;

	assign cfg_ready = 1'b1;
	assign act       = action_t'(s_tuser[0]);
	assign s1_en     = !s1_v_q || ld_ok;
	assign s_tready  = s1_en;
	assign s_acc     = s_tvalid && s_tready;

	always_comb begin
		req.adv   = s1_en;
		req.wr    = s_acc && (act == ACT_PUSH);
		req.col0  = (s_tdata[IDX_W-1:0] == '0);
		req.row0  = (s_tdata[2*IDX_W-1:IDX_W] == '0);
		req.dc    = s_tdata[2*IDX_W+DC_W-1:2*IDX_W];
		req.avail = s_tdata[2*IDX_W+DC_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s1_en) begin
			s1_v_q <= s_acc && (act == ACT_PREDICT);
		end
	end

	dcmp_line_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.req      (req),
		.nbr_s1   (nbr_s1)
	);

	dcmp_pred u_pred (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (s1_v_q),
		.nbr      (nbr_s1),
		.ld_ok    (ld_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_push_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (act == ACT_PUSH) |=> !s1_v_q)
		else $error("push transfer entered the read stage");

	a_predict_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (act == ACT_PREDICT) |=> s1_v_q)
		else $error("predict transfer lost before the read stage");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_v_q && m_tvalid && !m_tready)
		else $error("input stalled with room in the pipeline");

	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s1_v_q))
		else $error("output transfer without a predict in the read stage");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dc median predictor.
// A directed table covers an empty store, the store being emptied by a
// config write, the extreme dc values, masking in the first row and the
// first column, and the median, rounded mean, single-neighbor and
// no-neighbor outcomes. Random phases at several line lengths follow,
// including zero, saturating and long lines. A local line-store model
// predicts every reference the table does not fix, and each output
// transfer is compared in order. Both stream sides idle at random, and at
// one point the output is held off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
	import dcmp_pkg::*;

	localparam int   HOLD_OFF_CYCLES = 300;
	localparam int   STALL_LIMIT     = 5000;
	localparam int   SETTLE_CYCLES   = 8;
	localparam dc_t  DC_MAX          = 16'sh7fff;
	localparam dc_t  DC_MIN          = 16'sh8000;
	localparam int   NUM_PHASES      = 9;
	localparam int   PHASE_LINE [NUM_PHASES] = '{1, 0, 2, 3, 2047, 7, 1024, 0, 2};
	localparam int   PHASE_ITEMS[NUM_PHASES] = '{50, 40, 70, 60, 200, 60, 40, 60, 40};
	localparam int   PHASE_PUSH [NUM_PHASES] = '{50, 50, 50, 50, 90, 50, 60, 50, 40};
	localparam int   RANDOM_LINE_PHASE = 7;

	typedef struct {
		action_t          act;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] row;
		dc_t              dc;
		logic             avail;
	} item_t;

	typedef struct {
		bit               is_cfg;
		logic [CFG_W-1:0] line_val;
		item_t            it;
		bit               typed;
		dc_t              want;
	} step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic [0:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [DC_W-1:0]       m_tdata;

	// line store model
	logic             nb_ok [0:STORE_DEPTH-1];
	dc_t              nb_dc [0:STORE_DEPTH-1];
	int unsigned      oldest;
	logic [CFG_W-1:0] line_cfg;

	dc_t   pending_refs[$];
	dc_t   want_ref;
	int    fails;
	int    idle_cycles;
	int    hold_cycles;
	int    src_idle_pct;
	int    sink_idle_pct;
	step_t dir_steps[$];

	dc_median_predictor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int unsigned store_span();
		int unsigned n;
		n = line_cfg;
		if (n < 1) n = 1;
		if (n > MAX_LINE_BLOCKS) n = MAX_LINE_BLOCKS;
		return n + 1;
	endfunction

	function automatic void clear_store();
		for (int k = 0; k < STORE_DEPTH; k++) begin
			nb_ok[k] = 1'b0;
			nb_dc[k] = '0;
		end
		oldest = 0;
	endfunction

	function automatic void store_push(item_t it);
		int unsigned span;
		int unsigned p;
		span = store_span();
		p = oldest % span;
		nb_dc[p] = it.dc;
		nb_ok[p] = it.avail;
		oldest = (p + 1) % span;
	endfunction

	function automatic dc_t median3(dc_t a, dc_t b, dc_t c);
		dc_t lo;
		dc_t hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c <= lo) return lo;
		if (c >= hi) return hi;
		return c;
	endfunction

	// half away from zero
	function automatic dc_t round_mean(dc_t a, dc_t b);
		int s;
		s = a;
		s = s + b;
		if (s >= 0) return dc_t'((s + 1) / 2);
		return dc_t'(-((1 - s) / 2));
	endfunction

	function automatic dc_t predict_reference(item_t it);
		int unsigned span;
		int unsigned ia;
		int unsigned iu;
		int unsigned il;
		logic        col0;
		logic        row0;
		logic        ha;
		logic        hu;
		logic        hl;
		span = store_span();
		ia = oldest % span;
		iu = (ia + 1) % span;
		il = (ia + span - 1) % span;
		col0 = (it.col == 0);
		row0 = (it.row == 0);
		ha = nb_ok[ia] && !col0 && !row0;
		hu = nb_ok[iu] && !row0;
		hl = nb_ok[il] && !col0;
		case ({ha, hu, hl})
			3'b111: return median3(nb_dc[ia], nb_dc[iu], nb_dc[il]);
			3'b110: return round_mean(nb_dc[ia], nb_dc[iu]);
			3'b011: return round_mean(nb_dc[iu], nb_dc[il]);
			3'b101: return round_mean(nb_dc[ia], nb_dc[il]);
			3'b100: return nb_dc[ia];
			3'b010: return nb_dc[iu];
			3'b001: return nb_dc[il];
			default: return '0;
		endcase
	endfunction

	function automatic step_t pred_row(int col, int row, bit typed = 0, int want = 0);
		step_t st;
		st.is_cfg   = 1'b0;
		st.line_val = '0;
		st.it.act   = ACT_PREDICT;
		st.it.col   = IDX_W'(col);
		st.it.row   = IDX_W'(row);
		st.it.dc    = DC_MIN;
		st.it.avail = 1'b1;
		st.typed    = typed;
		st.want     = dc_t'(want);
		return st;
	endfunction

	function automatic step_t push_row(int dc, bit ok, int col = 0, int row = 0);
		step_t st;
		st.is_cfg   = 1'b0;
		st.line_val = '0;
		st.it.act   = ACT_PUSH;
		st.it.col   = IDX_W'(col);
		st.it.row   = IDX_W'(row);
		st.it.dc    = dc_t'(dc);
		st.it.avail = ok;
		st.typed    = 1'b0;
		st.want     = '0;
		return st;
	endfunction

	function automatic step_t cfg_row(int val);
		step_t st;
		st = push_row(0, 1'b0);
		st.is_cfg   = 1'b1;
		st.line_val = CFG_W'(val);
		return st;
	endfunction

	function automatic logic [IDX_W-1:0] rand_pos();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2) return '0;
		if (pick == 2) return '1;
		return IDX_W'($urandom_range(1, 4095));
	endfunction

	function automatic item_t rand_item(int push_pct);
		item_t it;
		int    pick;
		if ($urandom_range(0, 99) < push_pct) it.act = ACT_PUSH;
		else it.act = ACT_PREDICT;
		it.col = rand_pos();
		it.row = rand_pos();
		pick = $urandom_range(0, 9);
		case (pick)
			0: it.dc = DC_MAX;
			1: it.dc = DC_MIN;
			2, 3: it.dc = dc_t'($urandom_range(0, 8) - 4);
			default: it.dc = dc_t'($urandom());
		endcase
		it.avail = ($urandom_range(0, 99) < 80);
		return it;
	endfunction

	// entered and left at a falling edge
	task automatic send_item(item_t it, bit typed = 0, dc_t want = '0);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - 41){1'b0}}, it.avail, it.dc, it.row, it.col};
		s_tuser  <= it.act;
		do @(posedge clk); while (!s_tready);
		if (it.act == ACT_PUSH) store_push(it);
		else if (typed) pending_refs.push_back(want);
		else pending_refs.push_back(predict_reference(it));
		@(negedge clk);
	endtask

	task automatic write_line_blocks(logic [CFG_W-1:0] val);
		s_tvalid <= 1'b0;
		while (pending_refs.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		line_cfg = val;
		clear_store();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_refs.size() == 0) begin
				$error("reference: expected none, got %0d", $signed(m_tdata));
				fails++;
			end else begin
				want_ref = pending_refs.pop_front();
				if (m_tdata !== want_ref) begin
					$error("reference: expected %0d, got %0d", want_ref, $signed(m_tdata));
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [CFG_W-1:0] line_val;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		m_tready      = 1'b0;
		fails         = 0;
		idle_cycles   = 0;
		hold_cycles   = 0;
		src_idle_pct  = 25;
		sink_idle_pct = 53;
		line_cfg      = CFG_W'(MAX_LINE_BLOCKS);
		clear_store();

		dir_steps.push_back(pred_row(1, 1, 1, 0));
		dir_steps.push_back(push_row(500, 1));
		dir_steps.push_back(cfg_row(2));
		dir_steps.push_back(pred_row(1, 1, 1, 0));
		dir_steps.push_back(pred_row(4095, 4095, 1, 0));
		dir_steps.push_back(push_row(32767, 1));
		dir_steps.push_back(push_row(-32768, 1));
		dir_steps.push_back(push_row(100, 1, 4095, 4095));
		dir_steps.push_back(pred_row(1, 1));
		dir_steps.push_back(pred_row(0, 1));
		dir_steps.push_back(pred_row(1, 0));
		dir_steps.push_back(pred_row(0, 0, 1, 0));
		dir_steps.push_back(push_row(-32767, 0));
		dir_steps.push_back(pred_row(2048, 2048));
		dir_steps.push_back(push_row(1, 1));
		dir_steps.push_back(pred_row(1, 4095));
		dir_steps.push_back(push_row(2, 1));
		dir_steps.push_back(pred_row(4095, 1));
		dir_steps.push_back(push_row(-1, 1));
		dir_steps.push_back(pred_row(1, 1));
		dir_steps.push_back(push_row(-2, 1));
		dir_steps.push_back(pred_row(1, 1));
		dir_steps.push_back(push_row(5, 0));
		dir_steps.push_back(pred_row(1, 1));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_steps[k]) begin
			if (dir_steps[k].is_cfg) write_line_blocks(dir_steps[k].line_val);
			else send_item(dir_steps[k].it, dir_steps[k].typed, dir_steps[k].want);
		end

		// back up the input behind a long output stall
		write_line_blocks(CFG_W'(3));
		src_idle_pct = 0;
		hold_cycles = HOLD_OFF_CYCLES;
		repeat (60) send_item(rand_item(20));

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph * 3 / NUM_PHASES)
				0: begin
					src_idle_pct  = 25;
					sink_idle_pct = 53;
				end
				1: begin
					src_idle_pct  = 53;
					sink_idle_pct = 25;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			// one phase picks a random short line
			if (ph == RANDOM_LINE_PHASE) line_val = CFG_W'($urandom_range(4, 12));
			else line_val = CFG_W'(PHASE_LINE[ph]);
			write_line_blocks(line_val);
			repeat (PHASE_ITEMS[ph]) send_item(rand_item(PHASE_PUSH[ph]));
		end

		s_tvalid <= 1'b0;
		while (pending_refs.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fails == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
